// ----- rtl/murmur_hash_64b_stream_top_assert.svh -----
// ----------------------------------------------------------------------------
// assertion macros for the murmur hash stream block
// shared property forms, clocked on the rising edge and held off during reset
// ----------------------------------------------------------------------------
`ifndef MURMUR_HASH_64B_STREAM_TOP_ASSERT_SVH
`define MURMUR_HASH_64B_STREAM_TOP_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define MH64_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define MH64_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/mh64_pkg.sv -----
// ----------------------------------------------------------------------------
// mh64_pkg
// types and constants shared by the murmur hash stream front, back and top
// ----------------------------------------------------------------------------
package mh64_pkg;

  localparam logic [31:0] MIX_MUL    = 32'h5bd1e995;
  localparam int unsigned MIX_SHIFT  = 24;
  localparam logic [31:0] SEED_RESET = 32'hEE6B27EB;
  localparam int unsigned FMIX_SH1   = 18;
  localparam int unsigned FMIX_SH2   = 22;
  localparam int unsigned FMIX_SH3   = 17;
  localparam int unsigned FMIX_SH4   = 19;

  // what a word does to the lanes
  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_TAIL,
    KIND_FULL
  } kind_t;

  // one classified word waiting in the queue
  typedef struct packed {
    logic [31:0] word;     // tail words arrive already masked
    kind_t       kind;
    logic        first;
    logic        last;
    logic [31:0] h1_init;  // seed xor key length
  } entry_t;

  typedef struct packed {
    logic pop;   // back takes the queue head
    logic load;  // back loads the output register
  } back_status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISP,
    ST_W1,
    ST_W2,
    ST_W3,
    ST_T1,
    ST_F0,
    ST_F1,
    ST_F2,
    ST_F3,
    ST_F4,
    ST_OUT
  } st_t;

endpackage

// ----- rtl/mh64_front.sv -----
// ----------------------------------------------------------------------------
// mh64_front
// accepts key words, classifies them and holds them in a two-entry queue
// ----------------------------------------------------------------------------
module mh64_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [71:0]       s_axis_tdata,
  input  logic              s_axis_tlast,
  input  logic              s_axis_tuser,
  input  logic [31:0]       hash_seed,
  input  logic              pop,
  output logic              q_valid,
  output mh64_pkg::entry_t  q_entry
);

  mh64_pkg::entry_t slots [2];
  mh64_pkg::entry_t in_entry;
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic [31:0] key_word;
  logic [2:0]  valid_bytes;
  logic [31:0] key_length;

  assign key_word    = s_axis_tdata[31:0];
  assign valid_bytes = s_axis_tdata[34:32];
  assign key_length  = s_axis_tdata[66:35];

  always_comb begin
    in_entry.first   = s_axis_tuser;
    in_entry.last    = s_axis_tlast;
    in_entry.h1_init = hash_seed ^ key_length;
    in_entry.word    = key_word;
    in_entry.kind    = mh64_pkg::KIND_NONE;
    if (valid_bytes inside {[3'd4:3'd7]}) begin
      in_entry.kind = mh64_pkg::KIND_FULL;
    end else begin
      case (valid_bytes[1:0])
        2'd1: begin
          in_entry.kind = mh64_pkg::KIND_TAIL;
          in_entry.word = {24'd0, key_word[7:0]};
        end
        2'd2: begin
          in_entry.kind = mh64_pkg::KIND_TAIL;
          in_entry.word = {16'd0, key_word[15:0]};
        end
        2'd3: begin
          in_entry.kind = mh64_pkg::KIND_TAIL;
          in_entry.word = {8'd0, key_word[23:0]};
        end
        default: begin
          in_entry.kind = mh64_pkg::KIND_NONE;
        end
      endcase
    end
  end

  assign s_axis_tready = (count != 2'd2);
  assign push          = s_axis_tvalid && s_axis_tready;
  assign q_valid       = (count != 2'd0);
  assign q_entry       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_entry;
    end
  end

endmodule

// ----- rtl/mh64_back.sv -----
// ----------------------------------------------------------------------------
// mh64_back
// runs the word mix, lane folds and final mix on one shared multiplier
// ----------------------------------------------------------------------------
module mh64_back (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    q_valid,
  input  mh64_pkg::entry_t        q_entry,
  output mh64_pkg::back_status_t  status,
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  output logic [63:0]             m_axis_tdata
);

  mh64_pkg::st_t    state, state_next;
  mh64_pkg::entry_t cur, cur_next;
  logic [31:0] acc_high, acc_high_next;
  logic [31:0] acc_low, acc_low_next;
  logic        parity, parity_next;
  logic [31:0] kreg, kreg_next;
  logic [31:0] f1, f1_next;
  logic [31:0] f2, f2_next;
  logic [31:0] prod;
  logic [31:0] mul_in;
  logic [63:0] mul_full;
  logic        out_valid, out_valid_next;
  logic [63:0] out_data, out_data_next;

  // full product of the shared multiplier; only its low 32 bits are registered
  assign mul_full = mul_in * mh64_pkg::MIX_MUL;

  always_comb begin
    state_next     = state;
    cur_next       = cur;
    acc_high_next  = acc_high;
    acc_low_next   = acc_low;
    parity_next    = parity;
    kreg_next      = kreg;
    f1_next        = f1;
    f2_next        = f2;
    mul_in         = '0;
    out_valid_next = out_valid && !m_axis_tready;
    out_data_next  = out_data;
    status.pop     = 1'b0;
    status.load    = 1'b0;
    case (state)
      mh64_pkg::ST_IDLE: begin
        if (q_valid) begin
          status.pop = 1'b1;
          cur_next   = q_entry;
          if (q_entry.first) begin
            acc_high_next = q_entry.h1_init;
            acc_low_next  = '0;
            parity_next   = 1'b0;
          end
          state_next = mh64_pkg::ST_DISP;
        end
      end
      mh64_pkg::ST_DISP: begin
        case (cur.kind)
          mh64_pkg::KIND_FULL: begin
            mul_in     = cur.word;
            state_next = mh64_pkg::ST_W1;
          end
          mh64_pkg::KIND_TAIL: begin
            mul_in     = acc_low ^ cur.word;
            state_next = mh64_pkg::ST_T1;
          end
          default: begin
            state_next = cur.last ? mh64_pkg::ST_F0 : mh64_pkg::ST_IDLE;
          end
        endcase
      end
      mh64_pkg::ST_W1: begin
        mul_in     = prod ^ (prod >> mh64_pkg::MIX_SHIFT);
        state_next = mh64_pkg::ST_W2;
      end
      mh64_pkg::ST_W2: begin
        kreg_next  = prod;
        mul_in     = parity ? acc_low : acc_high;
        state_next = mh64_pkg::ST_W3;
      end
      mh64_pkg::ST_W3: begin
        if (parity) begin
          acc_low_next = prod ^ kreg;
        end else begin
          acc_high_next = prod ^ kreg;
        end
        parity_next = ~parity;
        state_next  = cur.last ? mh64_pkg::ST_F0 : mh64_pkg::ST_IDLE;
      end
      mh64_pkg::ST_T1: begin
        acc_low_next = prod;
        state_next   = cur.last ? mh64_pkg::ST_F0 : mh64_pkg::ST_IDLE;
      end
      // final mix works on copies, lanes keep their values
      mh64_pkg::ST_F0: begin
        mul_in     = acc_high ^ (acc_low >> mh64_pkg::FMIX_SH1);
        f2_next    = acc_low;
        state_next = mh64_pkg::ST_F1;
      end
      mh64_pkg::ST_F1: begin
        f1_next    = prod;
        mul_in     = f2 ^ (prod >> mh64_pkg::FMIX_SH2);
        state_next = mh64_pkg::ST_F2;
      end
      mh64_pkg::ST_F2: begin
        f2_next    = prod;
        mul_in     = f1 ^ (prod >> mh64_pkg::FMIX_SH3);
        state_next = mh64_pkg::ST_F3;
      end
      mh64_pkg::ST_F3: begin
        f1_next    = prod;
        mul_in     = f2 ^ (prod >> mh64_pkg::FMIX_SH4);
        state_next = mh64_pkg::ST_F4;
      end
      mh64_pkg::ST_F4: begin
        f2_next    = prod;
        state_next = mh64_pkg::ST_OUT;
      end
      mh64_pkg::ST_OUT: begin
        if (!out_valid || m_axis_tready) begin
          status.load    = 1'b1;
          out_valid_next = 1'b1;
          out_data_next  = {f1, f2};
          state_next     = mh64_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = mh64_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= mh64_pkg::ST_IDLE;
      acc_high  <= '0;
      acc_low   <= '0;
      parity    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      acc_high  <= acc_high_next;
      acc_low   <= acc_low_next;
      parity    <= parity_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    cur      <= cur_next;
    kreg     <= kreg_next;
    f1       <= f1_next;
    f2       <= f2_next;
    prod     <= mul_full[31:0];
    out_data <= out_data_next;
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

endmodule

// ----- rtl/murmur_hash_64b_stream_top.sv -----
// ----------------------------------------------------------------------------
// murmur_hash_64b_stream_top
// streaming murmurhash2 64b: key words in, 64-bit hash out on the last word
// ----------------------------------------------------------------------------
// A key arrives as little-endian 32-bit words; the hash leaves as one transfer
// after the word marked tlast. Words enter a two-entry queue at one per cycle
// while it has room, and are worked by one registered 32x32 multiplier: a word
// without bytes is only dispatched, a tail word of 1 to 3 bytes takes one lane
// multiply, a full word two mix multiplies and one lane multiply in series. The
// last word of a key adds the four final mix multiplies and the output load.
// The seed register may be written only while no key is in flight.
module murmur_hash_64b_stream_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        hash_seed_wr_en,
  input  logic [31:0] hash_seed_wr_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,   // key_word[31:0], valid_bytes[34:32], key_length[66:35]
  input  logic        s_axis_tlast,   // last_word
  input  logic        s_axis_tuser,   // first_word
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata    // hash_value[63:0]
);

  logic                   [31:0] hash_seed;
  logic                          q_valid;
  mh64_pkg::entry_t              q_entry;
  mh64_pkg::back_status_t        status;

  always_ff @(posedge clk) begin
    if (rst) begin
      hash_seed <= mh64_pkg::SEED_RESET;
    end else if (hash_seed_wr_en) begin
      hash_seed <= hash_seed_wr_data;
    end
  end

  mh64_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .hash_seed     (hash_seed),
    .pop           (status.pop),
    .q_valid       (q_valid),
    .q_entry       (q_entry)
  );

  mh64_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_entry       (q_entry),
    .status        (status),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

`include "murmur_hash_64b_stream_top_assert.svh"

  `MH64_ASSERT_NOW(a_pop_needs_entry, clk, rst, status.pop, q_valid, "pop from empty queue")
  `MH64_ASSERT_NOW(a_full_has_entry, clk, rst, !s_axis_tready, q_valid, "queue full yet empty")
  `MH64_ASSERT_NOW(a_no_overwrite, clk, rst, status.load, !m_axis_tvalid || m_axis_tready, "result overwritten")
  `MH64_ASSERT_NEXT(a_load_shows, clk, rst, status.load, m_axis_tvalid, "loaded result not shown")

endmodule
